// ===== rtl/qbrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// qbrrc_pkg
// shared types, constants and tap table of the qpsk/bpsk rrc modulator
// ----------------------------------------------------------------------------
package qbrrc_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int ACC_W         = 32;
   localparam int COEF_SLOTS    = 64;
   localparam int COEF_IDX_W    = 6;
   localparam int PHASE_W       = 3;   // holds a phase for up to eight samples per symbol
   localparam int SYM_W         = 2;
   localparam int SYMS_PER_BYTE = 4;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TX_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BPSK_SEL  = 1'd1;

   // operation codes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_IDLE = 1'b1;

   // constellation points, q1.15
   localparam logic signed [SAMPLE_W-1:0] QPSK_POS = 16'sd23166;
   localparam logic signed [SAMPLE_W-1:0] QPSK_NEG = -16'sd23167;
   localparam logic signed [SAMPLE_W-1:0] BPSK_POS = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] BPSK_NEG = -16'sd32768;

   // rrc taps in q1.15, zero padded to the largest tap count
   localparam logic signed [SAMPLE_W-1:0] COEF_TAB [COEF_SLOTS] = '{
      -16'sd256,   16'sd127,   16'sd638,   16'sd766,
      -16'sd256,  -16'sd2560, -16'sd4863, -16'sd3841,
       16'sd2559,  16'sd12032, 16'sd20480, 16'sd24576,
       16'sd20480, 16'sd12032, 16'sd2559, -16'sd3841,
      -16'sd4863, -16'sd2560, -16'sd256,   16'sd766,
       16'sd638,   16'sd127,  -16'sd256,   16'sd0,
       16'sd127,   16'sd127,   16'sd0,     16'sd0,
       16'sd0, 16'sd0, 16'sd0, 16'sd0,
       16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
       16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
       16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
       16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
   };

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       byte_last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_i;
      logic signed [SAMPLE_W-1:0] sample_q;
      logic                       sample_last;
   } rsp_type;

   // new symbol walking down the history, one cell per cycle while the chain runs
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sym_i;
      logic signed [SAMPLE_W-1:0] sym_q;
   } push_type;

   // output sample being accumulated as it walks down the cells
   typedef struct packed {
      logic               valid;
      logic               zero;
      logic               last;
      logic [PHASE_W-1:0] phase;
      logic [ACC_W-1:0]   acc_i;
      logic [ACC_W-1:0]   acc_q;
   } tok_type;

endpackage

// ===== rtl/qbrrc_seq.sv =====
// ----------------------------------------------------------------------------
// qbrrc_seq
// byte sequencer: splits a byte into symbols, maps them and issues samples
// ----------------------------------------------------------------------------
module qbrrc_seq
   import qbrrc_pkg::*;
#(
   parameter int SAMPLES_PER_SYMBOL = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     ce,
   input  logic     tx_enable,
   input  logic     bpsk_sel,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output push_type push_out,
   output tok_type  tok_out
);

   localparam int KW = (SAMPLES_PER_SYMBOL > 1) ? $clog2(SAMPLES_PER_SYMBOL) : 1;
   localparam logic [KW-1:0]    K_LAST   = KW'(SAMPLES_PER_SYMBOL - 1);
   localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(SYMS_PER_BYTE - 1);

   logic             busy_ff, busy_in;
   logic             idle_ff, idle_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [KW-1:0]    k_ff, k_in;
   tok_type          tok_ff, tok_in;

   logic       fin;
   logic       accept;
   logic [2:0] msb;
   logic [1:0] bits;

   assign fin       = busy_ff && (idle_ff || (sym_ff == SYM_LAST && k_ff == K_LAST));
   assign req_ready = ce && (!busy_ff || fin);
   assign accept    = req_valid && req_ready;

   // msb of the current pair: 7, 5, 3, 1
   assign msb  = {~sym_ff, 1'b1};
   assign bits = byte_ff[msb -: 2];

   // symbol push on the first phase of each symbol
   always_comb begin
      push_out.valid = busy_ff && !idle_ff && (k_ff == '0);
      if (bpsk_sel) begin
         push_out.sym_i = bits[1] ? BPSK_NEG : BPSK_POS;
         push_out.sym_q = '0;
      end else begin
         push_out.sym_i = bits[1] ? QPSK_NEG : QPSK_POS;
         push_out.sym_q = bits[0] ? QPSK_NEG : QPSK_POS;
      end
   end

   // sample token is registered in tok_ff, so it trails the push into the chain
   always_comb begin
      tok_in.valid = busy_ff;
      tok_in.zero  = idle_ff || !tx_enable;
      tok_in.last  = !idle_ff && last_ff && sym_ff == SYM_LAST && k_ff == K_LAST;
      tok_in.phase = PHASE_W'(k_ff);
      tok_in.acc_i = '0;
      tok_in.acc_q = '0;
   end

   always_comb begin
      busy_in = busy_ff;
      idle_in = idle_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      sym_in  = sym_ff;
      k_in    = k_ff;
      if (busy_ff && !fin) begin
         if (k_ff == K_LAST) begin
            k_in   = '0;
            sym_in = sym_ff + 1'b1;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end else if (accept) begin
         busy_in = 1'b1;
         idle_in = (req_payload.operation == OP_IDLE);
         byte_in = req_payload.data_byte;
         last_in = req_payload.byte_last;
         sym_in  = '0;
         k_in    = '0;
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
         sym_ff       <= '0;
         k_ff         <= '0;
      end else if (ce) begin
         busy_ff <= busy_in;
         tok_ff  <= tok_in;
         sym_ff  <= sym_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         idle_ff <= idle_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/qbrrc_cell.sv =====
// ----------------------------------------------------------------------------
// qbrrc_cell
// one history cell: holds one i/q symbol and adds its tap product to a sample
// ----------------------------------------------------------------------------
module qbrrc_cell
   import qbrrc_pkg::*;
#(
   parameter int CELL_IDX           = 0,
   parameter int SAMPLES_PER_SYMBOL = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     ce,
   input  push_type push_in,
   input  tok_type  tok_in,
   output push_type push_out,
   output tok_type  tok_out
);

   localparam int BASE = SAMPLES_PER_SYMBOL * CELL_IDX;

   logic signed [SAMPLE_W-1:0] hist_i_ff, hist_q_ff;
   push_type                   push_ff;
   tok_type                    tok_ff, tok_nx_in;

   logic [COEF_IDX_W-1:0]      cidx;
   logic signed [SAMPLE_W-1:0] coef;
   logic signed [ACC_W-1:0]    prod_i, prod_q;

   assign cidx   = COEF_IDX_W'(BASE) + COEF_IDX_W'(tok_in.phase);
   assign coef   = COEF_TAB[cidx];
   assign prod_i = hist_i_ff * coef;
   assign prod_q = hist_q_ff * coef;

   always_comb begin
      tok_nx_in       = tok_in;
      tok_nx_in.acc_i = tok_in.acc_i + prod_i;
      tok_nx_in.acc_q = tok_in.acc_q + prod_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_i_ff     <= '0;
         hist_q_ff     <= '0;
         push_ff.valid <= 1'b0;
         tok_ff.valid  <= 1'b0;
      end else if (ce) begin
         tok_ff        <= tok_nx_in;
         push_ff.valid <= push_in.valid;
         if (push_in.valid) begin
            // hand the displaced symbol to the next cell
            push_ff.sym_i <= hist_i_ff;
            push_ff.sym_q <= hist_q_ff;
            hist_i_ff     <= push_in.sym_i;
            hist_q_ff     <= push_in.sym_q;
         end
      end
   end

   assign push_out = push_ff;
   assign tok_out  = tok_ff;

endmodule

// ===== rtl/qpsk_bpsk_rrc_modulator_top.sv =====
// ----------------------------------------------------------------------------
// qpsk_bpsk_rrc_modulator_top
// qpsk/bpsk symbol mapper with polyphase root-raised-cosine pulse shaping
// ----------------------------------------------------------------------------
// usage
//  - req channel (valid/ready): one transaction carries a data byte or an
//    idle tick; a data byte gives 4 symbols, msb pair first, and
//    4 * SAMPLES_PER_SYMBOL samples (16 by default), an idle tick one zero sample
//  - rsp channel (valid/ready): one transaction per i/q sample
//  - csr port: csr_wr_en writes csr_wdata to register csr_index
//    (0 tx_enable, 1 bpsk_sel); change them only while the block is idle
//  - throughput: one sample per cycle while rsp is not held; the next
//    request is taken in the last cycle of the current one
//  - path: the first sample of a request passes the sequencer state, its
//    token register, each cell of the chain and the output register before
//    it shows on rsp_valid
//  - structure: the symbol history is a chain of TAP_COUNT/SAMPLES_PER_SYMBOL
//    cells; while the chain runs, a new symbol walks down it one cell a cycle
//    and each sample follows it, picking up one multiply-accumulate per cell
//  - stall: a held rsp fills a skid register; the whole chain then freezes
//    and req_ready drops until the skid drains, so no sample is lost
//  - reset: synchronous, clears history to zero and both registers to 0
module qpsk_bpsk_rrc_modulator_top
   import qbrrc_pkg::*;
#(
   parameter int TAP_COUNT          = 32,
   parameter int SAMPLES_PER_SYMBOL = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int HIST_LEN = TAP_COUNT / SAMPLES_PER_SYMBOL;

   // configuration registers
   logic tx_enable_ff, bpsk_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_enable_ff <= 1'b0;
         bpsk_sel_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TX_ENABLE: tx_enable_ff <= csr_wdata[0];
            CSR_BPSK_SEL:  bpsk_sel_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // chain advances as one unit unless the skid register is holding a sample
   logic     chain_ce;
   push_type push_chain [HIST_LEN+1];
   tok_type  tok_chain  [HIST_LEN+1];

   qbrrc_seq #(
      .SAMPLES_PER_SYMBOL(SAMPLES_PER_SYMBOL)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .ce         (chain_ce),
      .tx_enable  (tx_enable_ff),
      .bpsk_sel   (bpsk_sel_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .push_out   (push_chain[0]),
      .tok_out    (tok_chain[0])
   );

   for (genvar j = 0; j < HIST_LEN; j++) begin : g_cell
      qbrrc_cell #(
         .CELL_IDX          (j),
         .SAMPLES_PER_SYMBOL(SAMPLES_PER_SYMBOL)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ce      (chain_ce),
         .push_in (push_chain[j]),
         .tok_in  (tok_chain[j]),
         .push_out(push_chain[j+1]),
         .tok_out (tok_chain[j+1])
      );
   end

   // final sample: sum bits 30:15, forced to zero when disabled or idle
   tok_type tail;
   rsp_type tail_rsp;

   assign tail = tok_chain[HIST_LEN];

   always_comb begin
      tail_rsp.sample_i    = tail.zero ? '0 : tail.acc_i[30:15];
      tail_rsp.sample_q    = tail.zero ? '0 : tail.acc_q[30:15];
      tail_rsp.sample_last = tail.last;
   end

   // output register plus skid register
   logic    out_v_ff, out_v_in;
   rsp_type out_ff, out_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign chain_ce = !skid_v_ff;
   assign pop      = out_v_ff && rsp_ready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         // chain frozen, drain the skid first
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || pop) begin
         out_v_in = tail.valid;
         out_in   = tail_rsp;
      end else if (tail.valid) begin
         skid_v_in = 1'b1;
         skid_in   = tail_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   // skid only ever holds a sample behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register holds a sample with output register empty");

   // no new request while the chain is frozen
   a_no_req_on_stall: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !req_ready)
      else $error("request taken while chain is frozen");

   // a frozen chain keeps its tail sample
   a_tail_frozen: assert property (@(posedge clock) disable iff (reset)
      !chain_ce |=> $stable(tail))
      else $error("chain tail moved while frozen");

   // the skid fills only when the output register was full and held
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid filled without a stalled output");

endmodule
